[hdl/aabb_pkg.sv]
// Package for the box overlap and correction pipeline: fixed-point formats,
// stage payload types and the restoring divider step.
// No dependencies.
package aabb_pkg;

  localparam int unsigned COORD_BITS      = 21;
  localparam int unsigned FRAC_BITS       = 10;
  localparam int unsigned AXES            = 3;
  localparam int unsigned VEC_BITS        = AXES * COORD_BITS;
  localparam int unsigned WIDE_BITS       = COORD_BITS + 2;
  localparam int unsigned QUO_BITS        = FRAC_BITS + 1;
  localparam int unsigned REM_BITS        = COORD_BITS + 1;
  localparam int unsigned STEPS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES      = (QUO_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned T_BITS          = FRAC_BITS + 2;
  localparam int unsigned FAC_BITS        = FRAC_BITS + 3;
  localparam int unsigned PROD_BITS       = FAC_BITS + COORD_BITS;
  localparam int unsigned CORR_BITS       = COORD_BITS + 1;
  localparam int unsigned NUM_STAGES      = DIV_STAGES + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic signed [T_BITS-1:0]     tval_t;
  typedef logic signed [FAC_BITS-1:0]   fac_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CORR_BITS-1:0]  corr_t;

  localparam tval_t T_ONE       = tval_t'(1 << FRAC_BITS);
  localparam tval_t KEY_INVALID = tval_t'(-(1 << FRAC_BITS) - 1);
  localparam prod_t CORR_MAX    = prod_t'((1 << COORD_BITS) - 1);
  localparam prod_t CORR_MIN    = prod_t'(-(1 << COORD_BITS));

  typedef struct packed {
    logic                  ok;
    logic                  tneg;
    coord_t                d;
    logic [COORD_BITS-1:0] dmag;
    logic [REM_BITS-1:0]   rem;
    logic [QUO_BITS-1:0]   quo;
  } axis_t;

  typedef struct packed {
    logic                ovl_strict;
    logic                ovl_edge;
    logic [AXES-1:0]     gnd;
    axis_t [AXES-1:0]    ax;
  } div_item_t;

  typedef struct packed {
    logic                ovl_strict;
    logic                ovl_edge;
    fac_t [AXES-1:0]     fac;
    coord_t [AXES-1:0]   d;
  } fac_item_t;

  typedef struct packed {
    logic                ovl_strict;
    logic                ovl_edge;
    prod_t [AXES-1:0]    prod;
  } prod_item_t;

  function automatic axis_t div_step(axis_t a);
    axis_t               r;
    logic [REM_BITS-1:0] dx;
    r  = a;
    dx = REM_BITS'(a.dmag);
    if (a.rem >= dx) begin
      r.rem = a.rem - dx;
      r.quo = {a.quo[QUO_BITS-2:0], 1'b1};
    end else begin
      r.quo = {a.quo[QUO_BITS-2:0], 1'b0};
    end
    r.rem = {r.rem[REM_BITS-2:0], 1'b0};
    return r;
  endfunction

endpackage

[hdl/aabb_overlap_and_correction.sv]
// Stages from input transaction to result: input stage, four divider stages,
// time/select stage, multiply stage, saturate stage. Throughput: one transaction per cycle unless the output stalls.
// All stages advance together; a stalled output holds the whole pipe.
// Reset clears the stage valid bits only; no other state.
// Top level of the box overlap and correction pipeline; depends on aabb_pkg.
module aabb_overlap_and_correction import aabb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [VEC_BITS-1:0]  a_min_i,
  input  logic [VEC_BITS-1:0]  a_max_i,
  input  logic [VEC_BITS-1:0]  b_min_i,
  input  logic [VEC_BITS-1:0]  b_max_i,
  input  logic [VEC_BITS-1:0]  move_vec_i,
  input  logic [AXES-1:0]      ground_flags_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 overlap_strict_o,
  output logic                 overlap_edge_o,
  output logic [CORR_BITS-1:0] corr_x_o,
  output logic [CORR_BITS-1:0] corr_y_o,
  output logic [CORR_BITS-1:0] corr_z_o
);

  logic                  en;
  logic [NUM_STAGES-1:0] vld_q;
  div_item_t             div_d [DIV_STAGES+1];
  div_item_t             div_q [DIV_STAGES+1];
  fac_item_t             fac_d, fac_q;
  prod_item_t            prod_d, prod_q;
  logic                  strict_d, strict_q;
  logic                  edge_d, edge_q;
  corr_t [AXES-1:0]      corr_d, corr_q;

  assign en         = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // Decode lanes, test overlap, solve numerator, seed divider
  always_comb begin
    coord_t amin, amax, bmin, bmax, d;
    wide_t  ray, face, num;
    logic [WIDE_BITS-1:0] nmag;
    div_d[0] = '0;
    div_d[0].ovl_strict = 1'b1;
    div_d[0].ovl_edge   = 1'b1;
    div_d[0].gnd        = ground_flags_i;
    for (int i = 0; i < AXES; i++) begin
      amin = coord_t'(a_min_i[i*COORD_BITS +: COORD_BITS]);
      amax = coord_t'(a_max_i[i*COORD_BITS +: COORD_BITS]);
      bmin = coord_t'(b_min_i[i*COORD_BITS +: COORD_BITS]);
      bmax = coord_t'(b_max_i[i*COORD_BITS +: COORD_BITS]);
      d    = coord_t'(move_vec_i[i*COORD_BITS +: COORD_BITS]);
      if (!(amin < bmax && amax > bmin)) div_d[0].ovl_strict = 1'b0;
      if (!(amin <= bmax && amax >= bmin)) div_d[0].ovl_edge = 1'b0;
      if (d[COORD_BITS-1]) begin
        ray  = wide_t'(amin) - wide_t'(d);
        face = wide_t'(bmax);
      end else begin
        ray  = wide_t'(amax) - wide_t'(d);
        face = wide_t'(bmin);
      end
      num  = face - ray;
      nmag = num[WIDE_BITS-1] ? WIDE_BITS'(-num) : WIDE_BITS'(num);
      div_d[0].ax[i].d    = d;
      div_d[0].ax[i].dmag = d[COORD_BITS-1] ? COORD_BITS'(-d) : COORD_BITS'(d);
      div_d[0].ax[i].ok   = (d != '0) && (nmag <= WIDE_BITS'(div_d[0].ax[i].dmag));
      div_d[0].ax[i].tneg = num[WIDE_BITS-1] ^ d[COORD_BITS-1];
      div_d[0].ax[i].rem  = nmag[REM_BITS-1:0];
      div_d[0].ax[i].quo  = '0;
    end
    // Restoring divider, several quotient bits per stage
    for (int s = 1; s <= DIV_STAGES; s++) begin
      div_d[s] = div_q[s-1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if ((s - 1) * STEPS_PER_STAGE + j < QUO_BITS) begin
          for (int i = 0; i < AXES; i++) begin
            div_d[s].ax[i] = div_step(div_d[s].ax[i]);
          end
        end
      end
    end
  end

  // Signed time, keys, axis selection, correction factor
  always_comb begin
    tval_t [AXES-1:0] t, key;
    logic  [AXES-1:0] ok, apply, g;
    div_item_t        di;
    di = div_q[DIV_STAGES];
    g  = di.gnd;
    for (int i = 0; i < AXES; i++) begin
      ok[i]  = di.ax[i].ok;
      t[i]   = di.ax[i].tneg ? -tval_t'(di.ax[i].quo) : tval_t'(di.ax[i].quo);
      key[i] = ok[i] ? t[i] : KEY_INVALID;
    end
    apply[0] = ok[0] && (!g[1] || t[0] <= 0) &&
               (g[0] || (key[0] > key[1] && key[0] > key[2]));
    apply[1] = ok[1] && (!g[0] || t[1] <= 0) &&
               (g[1] || (key[1] > key[0] && key[1] > key[2]));
    apply[2] = ok[2] && ((!g[0] && !g[1]) || t[2] <= 0) &&
               (g[2] || (key[2] > key[0] && key[2] > key[1]));
    fac_d.ovl_strict = di.ovl_strict;
    fac_d.ovl_edge   = di.ovl_edge;
    for (int i = 0; i < AXES; i++) begin
      fac_d.fac[i] = apply[i] ? (fac_t'(T_ONE) - fac_t'(t[i])) : '0;
      fac_d.d[i]   = di.ax[i].d;
    end
  end

  always_comb begin
    prod_d.ovl_strict = fac_q.ovl_strict;
    prod_d.ovl_edge   = fac_q.ovl_edge;
    for (int i = 0; i < AXES; i++) begin
      prod_d.prod[i] = prod_t'(fac_q.fac[i]) * prod_t'(fac_q.d[i]);
    end
  end

  // Floor to coordinate format and saturate
  always_comb begin
    prod_t sh;
    strict_d = prod_q.ovl_strict;
    edge_d   = prod_q.ovl_edge;
    for (int i = 0; i < AXES; i++) begin
      sh = prod_q.prod[i] >>> FRAC_BITS;
      if (sh > CORR_MAX) begin
        corr_d[i] = corr_t'(CORR_MAX);
      end else if (sh < CORR_MIN) begin
        corr_d[i] = corr_t'(CORR_MIN);
      end else begin
        corr_d[i] = corr_t'(sh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        div_q[s] <= div_d[s];
      end
      fac_q    <= fac_d;
      prod_q   <= prod_d;
      strict_q <= strict_d;
      edge_q   <= edge_d;
      corr_q   <= corr_d;
    end
  end

  assign out_valid_o      = vld_q[NUM_STAGES-1];
  assign overlap_strict_o = strict_q;
  assign overlap_edge_o   = edge_q;
  assign corr_x_o         = corr_q[0];
  assign corr_y_o         = corr_q[1];
  assign corr_z_o         = corr_q[2];

endmodule
